// File: sv/dpas_pkg.sv
`default_nettype none

package dpas_pkg;

    localparam int TASK_SLOTS = 16;
    localparam int IDX_W      = $clog2(TASK_SLOTS);
    localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_ARRIVE   = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [15:0] work;
        logic [7:0]  prio;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARRIVE,
        ST_FCHK,
        ST_FEVAL,
        ST_SHIFT,
        ST_SCAN,
        ST_UPDATE,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        MODE_SHIFT,
        MODE_SCAN,
        MODE_UPDATE
    } t_mode;

    typedef struct packed {
        logic  load;
        logic  count_tick;
        logic  arrive;
        logic  fchk_rd;
        logic  finish;
        logic  init;
        logic  from_last;
        logic  step;
        t_mode mode;
        logic  shift_end;
        logic  emit;
    } t_cmd;

    typedef struct packed {
        logic fchk_ok;
        logic fin_zero;
        logic sweep_done;
    } t_stat;

endpackage

`default_nettype wire

// File: sv/dynamic_priority_aging_scheduler.sv
// Arrival: ARRIVE, EMIT, then the result strobe; busy drops as the result shows.
// Tick: FCHK; FEVAL if the previous tick ran a task; SHIFT when that task has finished,
//   compacting the table from the slot after it; then SCAN, UPDATE and EMIT.
// The slot table is one single-port-read memory; each pass (compact, min scan, aging)
//   reads one slot a cycle, so a new item is taken once the previous result shows.
// Synchronous active-low reset empties the table and clears the tick count.
`default_nettype none

module dynamic_priority_aging_scheduler import dpas_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [7:0]  i_task_id,
    input  logic [15:0] i_work_time,
    input  logic [7:0]  i_start_priority,
    output logic        o_valid,
    output logic        o_status,
    output logic        o_finished_valid,
    output logic [7:0]  o_finished_id,
    output logic        o_run_valid,
    output logic [7:0]  o_run_id,
    output logic [7:0]  o_run_priority,
    output logic [15:0] o_tick_time,
    output logic        o_table_empty
);

    t_cmd  cmd;
    t_stat stat;

    dpas_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    dpas_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_task_id        (i_task_id),
        .i_work_time      (i_work_time),
        .i_start_priority (i_start_priority),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_finished_valid (o_finished_valid),
        .o_finished_id    (o_finished_id),
        .o_run_valid      (o_run_valid),
        .o_run_id         (o_run_id),
        .o_run_priority   (o_run_priority),
        .o_tick_time      (o_tick_time),
        .o_table_empty    (o_table_empty)
    );

endmodule

`default_nettype wire

// File: sv/dpas_ctrl.sv
`default_nettype none

module dpas_ctrl import dpas_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  logic  i_opcode,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = (i_opcode == OP_ARRIVE) ? ST_ARRIVE : ST_FCHK;
                end
            end
            ST_ARRIVE: n_state = ST_EMIT;
            ST_FCHK:   n_state = i_stat.fchk_ok ? ST_FEVAL : ST_SCAN;
            ST_FEVAL:  n_state = i_stat.fin_zero ? ST_SHIFT : ST_SCAN;
            ST_SHIFT: begin
                if (i_stat.sweep_done) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_stat.sweep_done) n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (i_stat.sweep_done) n_state = ST_EMIT;
            end
            ST_EMIT:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.mode = MODE_SCAN;
        case (r_state)
            ST_IDLE: begin
                o_cmd.load       = start;
                o_cmd.count_tick = start && (i_opcode == OP_TICK);
            end
            ST_ARRIVE: o_cmd.arrive = 1'b1;
            ST_FCHK: begin
                o_cmd.fchk_rd = i_stat.fchk_ok;
                o_cmd.init    = !i_stat.fchk_ok;
            end
            ST_FEVAL: begin
                // finished task: compact the table from the slot after it; else scan from slot 0
                o_cmd.init      = 1'b1;
                o_cmd.from_last = i_stat.fin_zero;
                o_cmd.finish    = i_stat.fin_zero;
            end
            ST_SHIFT: begin
                o_cmd.step      = 1'b1;
                o_cmd.mode      = MODE_SHIFT;
                o_cmd.shift_end = i_stat.sweep_done;
                o_cmd.init      = i_stat.sweep_done;
            end
            ST_SCAN: begin
                o_cmd.step = 1'b1;
                o_cmd.mode = MODE_SCAN;
                o_cmd.init = i_stat.sweep_done;
            end
            ST_UPDATE: begin
                o_cmd.step = 1'b1;
                o_cmd.mode = MODE_UPDATE;
            end
            ST_EMIT:  o_cmd.emit = 1'b1;
            default:  o_cmd.emit = 1'b0;
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

// File: sv/dpas_dp.sv
`default_nettype none

module dpas_dp import dpas_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [7:0]  i_task_id,
    input  logic [15:0] i_work_time,
    input  logic [7:0]  i_start_priority,
    output logic        o_valid,
    output logic        o_status,
    output logic        o_finished_valid,
    output logic [7:0]  o_finished_id,
    output logic        o_run_valid,
    output logic [7:0]  o_run_id,
    output logic [7:0]  o_run_priority,
    output logic [15:0] o_tick_time,
    output logic        o_table_empty
);

    t_entry r_mem [TASK_SLOTS];
    t_entry r_rdata;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    t_entry           mem_wdata;
    t_entry           upd;
    logic             issue;

    logic [CNT_W-1:0] r_count,     n_count;
    logic             r_last_valid, n_last_valid;
    logic [IDX_W-1:0] r_last_slot, n_last_slot;
    logic [15:0]      r_tick,      n_tick;
    logic [CNT_W-1:0] r_idx,       n_idx;
    logic [IDX_W-1:0] r_pidx,      n_pidx;
    logic             r_pvld,      n_pvld;
    logic [IDX_W-1:0] r_best,      n_best;
    logic [7:0]       r_best_pr,   n_best_pr;
    t_entry           r_in,        n_in;

    logic             r_res_status, n_res_status;
    logic             r_res_fin_v,  n_res_fin_v;
    logic [7:0]       r_res_fin_id, n_res_fin_id;
    logic             r_res_run_v,  n_res_run_v;
    logic [7:0]       r_res_run_id, n_res_run_id;
    logic [7:0]       r_res_run_pr, n_res_run_pr;
    logic [15:0]      r_res_time,   n_res_time;

    logic             r_o_valid,  n_o_valid;
    logic             r_o_status, n_o_status;
    logic             r_o_fin_v,  n_o_fin_v;
    logic [7:0]       r_o_fin_id, n_o_fin_id;
    logic             r_o_run_v,  n_o_run_v;
    logic [7:0]       r_o_run_id, n_o_run_id;
    logic [7:0]       r_o_run_pr, n_o_run_pr;
    logic [15:0]      r_o_time,   n_o_time;
    logic             r_o_empty,  n_o_empty;

    assign issue             = (r_idx < r_count);
    assign o_stat.sweep_done = !issue;
    assign o_stat.fchk_ok    = r_last_valid && (CNT_W'(r_last_slot) < r_count);
    assign o_stat.fin_zero   = (r_rdata.work == 16'd0);
    assign mem_raddr         = i_cmd.fchk_rd ? r_last_slot : r_idx[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_comb begin
        n_count      = r_count;
        n_last_valid = r_last_valid;
        n_last_slot  = r_last_slot;
        n_tick       = r_tick;
        n_idx        = r_idx;
        n_pidx       = r_pidx;
        n_pvld       = r_pvld;
        n_best       = r_best;
        n_best_pr    = r_best_pr;
        n_in         = r_in;
        n_res_status = r_res_status;
        n_res_fin_v  = r_res_fin_v;
        n_res_fin_id = r_res_fin_id;
        n_res_run_v  = r_res_run_v;
        n_res_run_id = r_res_run_id;
        n_res_run_pr = r_res_run_pr;
        n_res_time   = r_res_time;
        mem_we       = 1'b0;
        mem_waddr    = r_pidx;
        mem_wdata    = r_rdata;
        upd          = r_rdata;

        if (i_cmd.load) begin
            n_in.task_id = i_task_id;
            n_in.work    = i_work_time;
            n_in.prio    = i_start_priority;
            n_res_status = STATUS_OK;
            n_res_fin_v  = 1'b0;
            n_res_fin_id = 8'd0;
            n_res_run_v  = 1'b0;
            n_res_run_id = 8'd0;
            n_res_run_pr = 8'd0;
            n_res_time   = r_tick;
        end
        if (i_cmd.count_tick) begin
            n_tick = r_tick + 16'd1;
        end

        if (i_cmd.arrive) begin
            if (r_count == CNT_W'(TASK_SLOTS)) begin
                n_res_status = STATUS_FULL;
            end else begin
                mem_we    = 1'b1;
                mem_waddr = r_count[IDX_W-1:0];
                mem_wdata = r_in;
                n_count   = r_count + CNT_W'(1);
            end
        end

        if (i_cmd.finish) begin
            n_res_fin_v  = 1'b1;
            n_res_fin_id = r_rdata.task_id;
            n_last_valid = 1'b0;
        end

        if (i_cmd.init) begin
            n_idx  = i_cmd.from_last ? CNT_W'(r_last_slot) + CNT_W'(1) : '0;
            n_pvld = 1'b0;
        end

        // one read issued per cycle, its data handled the cycle after
        if (i_cmd.step) begin
            n_pvld = issue;
            if (issue) begin
                n_idx  = r_idx + CNT_W'(1);
                n_pidx = r_idx[IDX_W-1:0];
            end
            if (r_pvld) begin
                case (i_cmd.mode)
                    MODE_SHIFT: begin
                        mem_we    = 1'b1;
                        mem_waddr = r_pidx - IDX_W'(1);
                    end
                    MODE_SCAN: begin
                        // strict compare keeps the earliest slot on ties
                        if (r_pidx == '0 || r_rdata.prio < r_best_pr) begin
                            n_best    = r_pidx;
                            n_best_pr = r_rdata.prio;
                        end
                    end
                    MODE_UPDATE: begin
                        if (r_pidx == r_best) begin
                            if (r_rdata.work != 16'd0) upd.work = r_rdata.work - 16'd1;
                            if (r_rdata.prio != 8'hFF) upd.prio = r_rdata.prio + 8'd1;
                            n_res_run_v  = 1'b1;
                            n_res_run_id = r_rdata.task_id;
                            n_res_run_pr = upd.prio;
                            n_last_valid = 1'b1;
                            n_last_slot  = r_best;
                        end else if (r_rdata.prio != 8'd0) begin
                            upd.prio = r_rdata.prio - 8'd1;
                        end
                        mem_we    = 1'b1;
                        mem_wdata = upd;
                    end
                    default: mem_we = 1'b0;
                endcase
            end
        end

        if (i_cmd.shift_end) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        n_o_valid  = i_cmd.emit;
        n_o_status = r_o_status;
        n_o_fin_v  = r_o_fin_v;
        n_o_fin_id = r_o_fin_id;
        n_o_run_v  = r_o_run_v;
        n_o_run_id = r_o_run_id;
        n_o_run_pr = r_o_run_pr;
        n_o_time   = r_o_time;
        n_o_empty  = r_o_empty;
        if (i_cmd.emit) begin
            n_o_status = r_res_status;
            n_o_fin_v  = r_res_fin_v;
            n_o_fin_id = r_res_fin_id;
            n_o_run_v  = r_res_run_v;
            n_o_run_id = r_res_run_id;
            n_o_run_pr = r_res_run_pr;
            n_o_time   = r_res_time;
            n_o_empty  = (r_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_last_valid <= 1'b0;
            r_last_slot  <= '0;
            r_tick       <= 16'd0;
            r_idx        <= '0;
            r_pvld       <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_last_valid <= n_last_valid;
            r_last_slot  <= n_last_slot;
            r_tick       <= n_tick;
            r_idx        <= n_idx;
            r_pvld       <= n_pvld;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx       <= n_pidx;
        r_best       <= n_best;
        r_best_pr    <= n_best_pr;
        r_in         <= n_in;
        r_res_status <= n_res_status;
        r_res_fin_v  <= n_res_fin_v;
        r_res_fin_id <= n_res_fin_id;
        r_res_run_v  <= n_res_run_v;
        r_res_run_id <= n_res_run_id;
        r_res_run_pr <= n_res_run_pr;
        r_res_time   <= n_res_time;
        r_o_status   <= n_o_status;
        r_o_fin_v    <= n_o_fin_v;
        r_o_fin_id   <= n_o_fin_id;
        r_o_run_v    <= n_o_run_v;
        r_o_run_id   <= n_o_run_id;
        r_o_run_pr   <= n_o_run_pr;
        r_o_time     <= n_o_time;
        r_o_empty    <= n_o_empty;
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_finished_valid = r_o_fin_v;
    assign o_finished_id    = r_o_fin_id;
    assign o_run_valid      = r_o_run_v;
    assign o_run_id         = r_o_run_id;
    assign o_run_priority   = r_o_run_pr;
    assign o_tick_time      = r_o_time;
    assign o_table_empty    = r_o_empty;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TASK_SLOTS))
        else $error("task count beyond table size");

    a_last_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last_valid |-> (CNT_W'(r_last_slot) < r_count))
        else $error("last-run slot outside the table");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |=> !r_o_valid)
        else $error("result strobe held for two cycles");

    a_full_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status) |-> (!r_o_run_v && !r_o_fin_v && !r_o_empty))
        else $error("dropped arrival reported with tick results");

endmodule

`default_nettype wire
